// ===== hdl/jsu_pkg.sv =====
// Types, character codes and UTF-8 helpers for the JSON string unescaper.
// Used by jsu_decode, jsu_serial and the json_string_unescape top level.
package jsu_pkg;

  // Escape decoder phase
  typedef enum logic [2:0] {
    PH_PLAIN   = 3'd0,
    PH_ESC     = 3'd1,
    PH_HEX1    = 3'd2,
    PH_WANT_BS = 3'd3,
    PH_WANT_U  = 3'd4,
    PH_HEX2    = 3'd5
  } phase_t;

  // Character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_LC_A   = 8'h61;

  localparam logic [7:0] CTRL_BS = 8'h08;
  localparam logic [7:0] CTRL_FF = 8'h0C;
  localparam logic [7:0] CTRL_LF = 8'h0A;
  localparam logic [7:0] CTRL_CR = 8'h0D;
  localparam logic [7:0] CTRL_HT = 8'h09;

  localparam logic [15:0] SURR_LO     = 16'hD800;
  localparam logic [15:0] SURR_HI     = 16'hDFFF;
  localparam logic [15:0] LOW_SURR_LO = 16'hDC00;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  localparam int GRP_MAX = 4;

  // One result beat
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       bad;
    logic       last;
  } res_t;

  // Results caused by one input beat
  typedef struct packed {
    res_t [GRP_MAX-1:0] ent;
    logic [1:0]         cnt_m1;  // number of results minus one
    logic               any;     // at least one result
  } grp_t;

  function automatic grp_t grp_one(logic [7:0] d, logic bv, logic bad);
    grp_t g;
    g = '0;
    g.ent[0] = '{data: d, byte_valid: bv, bad: bad, last: 1'b0};
    g.any = 1'b1;
    return g;
  endfunction

  function automatic logic [3:0] nibble(logic [7:0] c);
    logic [7:0] v;
    if (c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c < CH_LC_A) begin
      v = c - CH_UC_A + 8'd10;
    end else begin
      v = c - CH_LC_A + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic grp_t utf8(logic [20:0] cp);
    grp_t g;
    g = '0;
    g.any = 1'b1;
    if (cp < 21'h80) begin
      g.ent[0] = '{data: cp[7:0], byte_valid: 1'b1, bad: 1'b0, last: 1'b0};
      g.cnt_m1 = 2'd0;
    end else if (cp < 21'h800) begin
      g.ent[0] = '{data: {3'b110, cp[10:6]}, byte_valid: 1'b1, bad: 1'b0, last: 1'b0};
      g.ent[1] = '{data: {2'b10, cp[5:0]}, byte_valid: 1'b1, bad: 1'b0, last: 1'b0};
      g.cnt_m1 = 2'd1;
    end else if (cp < SUPP_BASE) begin
      g.ent[0] = '{data: {4'b1110, cp[15:12]}, byte_valid: 1'b1, bad: 1'b0, last: 1'b0};
      g.ent[1] = '{data: {2'b10, cp[11:6]}, byte_valid: 1'b1, bad: 1'b0, last: 1'b0};
      g.ent[2] = '{data: {2'b10, cp[5:0]}, byte_valid: 1'b1, bad: 1'b0, last: 1'b0};
      g.cnt_m1 = 2'd2;
    end else begin
      g.ent[0] = '{data: {5'b11110, cp[20:18]}, byte_valid: 1'b1, bad: 1'b0, last: 1'b0};
      g.ent[1] = '{data: {2'b10, cp[17:12]}, byte_valid: 1'b1, bad: 1'b0, last: 1'b0};
      g.ent[2] = '{data: {2'b10, cp[11:6]}, byte_valid: 1'b1, bad: 1'b0, last: 1'b0};
      g.ent[3] = '{data: {2'b10, cp[5:0]}, byte_valid: 1'b1, bad: 1'b0, last: 1'b0};
      g.cnt_m1 = 2'd3;
    end
    return g;
  endfunction

endpackage

// ===== hdl/jsu_in_if.sv =====
// Input channel: raw escaped bytes with an end-of-string flag.
// Standalone; no package needed.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, in_byte, end_of_string, input ready);
  modport sink   (input valid, in_byte, end_of_string, output ready);
endinterface

// ===== hdl/jsu_out_if.sv =====
// Output channel: decoded bytes with valid, error and last flags.
// Standalone; no package needed.
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       bad_escape;
  logic       last;

  modport source (output valid, out_byte, byte_valid, bad_escape, last, input ready);
  modport sink   (input valid, out_byte, byte_valid, bad_escape, last, output ready);
endinterface

// ===== hdl/jsu_decode.sv =====
// Escape decoder: phase state, hex accumulation and result group forming.
// Depends on jsu_pkg.
module jsu_decode import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  output grp_t       grp
);

  phase_t      phase, phase_next;
  logic [1:0]  hcnt, hcnt_next;
  logic [15:0] first_unit, first_unit_next;
  logic [15:0] second_unit, second_unit_next;
  logic        dropping, dropping_next;
  logic        err;
  logic [3:0]  nib;
  grp_t        g;

  assign nib = nibble(in_byte);

  always_comb begin
    phase_next       = phase;
    hcnt_next        = hcnt;
    first_unit_next  = first_unit;
    second_unit_next = second_unit;
    dropping_next    = dropping;
    err              = 1'b0;
    g                = '0;

    if (!dropping) begin
      case (phase)
        PH_ESC: begin
          phase_next = PH_PLAIN;
          case (in_byte)
            CH_U: begin
              phase_next      = PH_HEX1;
              hcnt_next       = 2'd0;
              first_unit_next = '0;
            end
            CH_B:    g = grp_one(CTRL_BS, 1'b1, 1'b0);
            CH_F:    g = grp_one(CTRL_FF, 1'b1, 1'b0);
            CH_N:    g = grp_one(CTRL_LF, 1'b1, 1'b0);
            CH_R:    g = grp_one(CTRL_CR, 1'b1, 1'b0);
            CH_T:    g = grp_one(CTRL_HT, 1'b1, 1'b0);
            default: g = grp_one(in_byte, 1'b1, 1'b0);  // unknown escape: literal
          endcase
        end
        PH_HEX1: begin
          first_unit_next = {first_unit[11:0], nib};
          hcnt_next       = hcnt + 2'd1;
          if (hcnt == 2'd3) begin
            if (first_unit_next inside {[SURR_LO:SURR_HI]}) begin
              phase_next = PH_WANT_BS;
            end else begin
              g          = utf8({5'd0, first_unit_next});
              phase_next = PH_PLAIN;
            end
          end
        end
        PH_WANT_BS: begin
          if (in_byte == CH_BSLASH) begin
            phase_next = PH_WANT_U;
          end else begin
            err = 1'b1;
          end
        end
        PH_WANT_U: begin
          if (in_byte == CH_U) begin
            phase_next       = PH_HEX2;
            hcnt_next        = 2'd0;
            second_unit_next = '0;
          end else begin
            err = 1'b1;
          end
        end
        PH_HEX2: begin
          second_unit_next = {second_unit[11:0], nib};
          hcnt_next        = hcnt + 2'd1;
          if (hcnt == 2'd3) begin
            if (second_unit_next inside {[LOW_SURR_LO:SURR_HI]}) begin
              g = utf8(SUPP_BASE + {1'b0, first_unit[9:0], second_unit_next[9:0]});
              phase_next = PH_PLAIN;
            end else begin
              err = 1'b1;
            end
          end
        end
        default: begin
          if (in_byte == CH_BSLASH) begin
            phase_next = PH_ESC;
          end else begin
            g = grp_one(in_byte, 1'b1, 1'b0);
          end
        end
      endcase
      // string cut off inside an escape
      if (!err && end_of_string && phase_next != PH_PLAIN) begin
        err = 1'b1;
      end
    end

    // error beat is always the only result of its input beat
    if (err) begin
      g             = grp_one(8'h00, 1'b0, 1'b1);
      dropping_next = 1'b1;
      phase_next    = PH_PLAIN;
      hcnt_next     = 2'd0;
    end

    if (end_of_string) begin
      if (!g.any) begin
        g = grp_one(8'h00, 1'b0, 1'b0);
      end
      g.ent[g.cnt_m1].last = 1'b1;
      phase_next       = PH_PLAIN;
      hcnt_next        = 2'd0;
      first_unit_next  = '0;
      second_unit_next = '0;
      dropping_next    = 1'b0;
    end
  end

  assign grp = g;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_PLAIN;
      hcnt        <= 2'd0;
      first_unit  <= '0;
      second_unit <= '0;
      dropping    <= 1'b0;
    end else if (fire) begin
      phase       <= phase_next;
      hcnt        <= hcnt_next;
      first_unit  <= first_unit_next;
      second_unit <= second_unit_next;
      dropping    <= dropping_next;
    end
  end

  a_drop_plain: assert property (@(posedge clk) disable iff (rst)
    dropping |-> phase == PH_PLAIN)
    else $error("dropping outside plain phase");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    fire && end_of_string |=> phase == PH_PLAIN && !dropping && hcnt == 2'd0)
    else $error("state not cleared after end of string");

  a_end_has_last: assert property (@(posedge clk) disable iff (rst)
    fire && end_of_string |-> grp.any && grp.ent[grp.cnt_m1].last)
    else $error("end of string without last result");

endmodule

// ===== hdl/jsu_serial.sv =====
// Result register: holds one group of up to four results and sends them
// one beat at a time. Depends on jsu_pkg and jsu_out_if.
module jsu_serial import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  grp_t      grp_in,
  output logic      can_load,
  jsu_out_if.source tx
);

  grp_t       grp;
  logic       grp_valid;
  logic [1:0] idx;
  logic       take;
  logic       done;
  res_t       cur;

  assign take     = grp_valid && tx.ready;
  assign done     = take && (idx == grp.cnt_m1);
  assign can_load = !grp_valid || done;

  assign cur           = grp.ent[idx];
  assign tx.valid      = grp_valid;
  assign tx.out_byte   = cur.data;
  assign tx.byte_valid = cur.byte_valid;
  assign tx.bad_escape = cur.bad;
  assign tx.last       = cur.last;

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      grp_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (done) begin
      grp_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    grp_valid |-> idx <= grp.cnt_m1)
    else $error("result index past group end");

  a_last_final: assert property (@(posedge clk) disable iff (rst)
    grp_valid && tx.last |-> idx == grp.cnt_m1)
    else $error("last flag before final beat of group");

  a_load_ok: assert property (@(posedge clk) disable iff (rst)
    load |-> can_load)
    else $error("group loaded over pending results");

endmodule

// ===== hdl/json_string_unescape.sv =====
// JSON string body unescaper with UTF-8 output, top level.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if, jsu_decode, jsu_serial.
//
//   channel | dir | payload                                    | beat
//   rx      | in  | in_byte, end_of_string                     | one raw byte
//   tx      | out | out_byte, byte_valid, bad_escape, last     | one result
//
// One input beat is decoded per cycle while rx.ready is high, into a group
// of 0 to 4 results held in the result register; the group leaves at one
// beat per cycle while tx.ready is high. rx.ready is high when the result
// register is empty or sends its final beat in this cycle, so plain bytes
// flow bubble-free at one per cycle; a multi-byte \uXXXX holds the input.
// Synchronous active-high reset clears the decoder state and the register.
module json_string_unescape import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  jsu_in_if.sink    rx,
  jsu_out_if.source tx
);

  grp_t grp;
  logic fire;
  logic can_load;

  assign rx.ready = can_load;
  assign fire     = rx.valid && rx.ready;

  jsu_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .in_byte       (rx.in_byte),
    .end_of_string (rx.end_of_string),
    .grp           (grp)
  );

  jsu_serial u_serial (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && grp.any),
    .grp_in   (grp),
    .can_load (can_load),
    .tx       (tx)
  );

endmodule
